// ===== hdl/fhv_pkg.sv =====
// Shared types and constants for the floating horizon visibility unit.
package fhv_pkg;

  localparam int CURVE_POINTS  = 512;
  localparam int SCREEN_HEIGHT = 1024;
  localparam int HORIZON_WIDTH = 512;
  localparam int X_LIMIT       = (CURVE_POINTS < HORIZON_WIDTH) ? CURVE_POINTS : HORIZON_WIDTH;

  localparam int Y_W    = 12;
  localparam int ADDR_W = $clog2(HORIZON_WIDTH);
  localparam int POS_W  = $clog2(HORIZON_WIDTH + 1);

  typedef enum logic [1:0] {
    VIS_HIDDEN = 2'd0,
    VIS_ABOVE  = 2'd1,
    VIS_BELOW  = 2'd2
  } vis_t;

  typedef struct packed {
    logic [POS_W-1:0] x;
    logic             start;
    logic             drop;
  } point_t;

  typedef struct packed {
    logic signed [Y_W-1:0] upper;
    logic signed [Y_W-1:0] lower;
  } horizon_t;

  localparam int HOR_W = $bits(horizon_t);

  localparam logic signed [Y_W-1:0] UPPER_RESET = '0;
  localparam logic signed [Y_W-1:0] LOWER_RESET = Y_W'(SCREEN_HEIGHT);

endpackage

// ===== hdl/fhv_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module fhv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/fhv_point_gen.sv =====
// Curve position counter: gives x, curve start and drop flag of the incoming sample.
module fhv_point_gen (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  logic            first_point,
  output fhv_pkg::point_t pt
);

  logic [fhv_pkg::POS_W-1:0] position;

  always_comb begin
    pt.start = first_point || (position == '0);
    pt.x     = pt.start ? '0 : position;
    pt.drop  = (pt.x >= fhv_pkg::POS_W'(fhv_pkg::X_LIMIT));
  end

  // position saturates on a dropped sample until the next curve start
  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
    end else if (accept && !pt.drop) begin
      position <= pt.x + fhv_pkg::POS_W'(1);
    end
  end

endmodule

// ===== hdl/fhv_widen.sv =====
// Classifies a height against the horizons at x and forms the widened horizons.
module fhv_widen (
  input  logic signed [fhv_pkg::Y_W-1:0] y,
  input  fhv_pkg::horizon_t              cur,
  output fhv_pkg::vis_t                  cls,
  output fhv_pkg::horizon_t              nxt
);

  always_comb begin
    if ((y < cur.upper) && (y > cur.lower)) begin
      cls = fhv_pkg::VIS_HIDDEN;
    end else if (y >= cur.upper) begin
      cls = fhv_pkg::VIS_ABOVE;
    end else begin
      cls = fhv_pkg::VIS_BELOW;
    end
    // a hidden height lies strictly between the two, so this is then a no-op
    nxt.upper = (y > cur.upper) ? y : cur.upper;
    nxt.lower = (y < cur.lower) ? y : cur.lower;
  end

endmodule

// ===== hdl/floating_horizon_visibility_unit.sv =====
// Pipeline: an accepted sample is registered in stage 1 with its RAM read, then its result word
// is registered at the output; a result stall holds stage 1. Throughput: one sample per cycle
// while the result side is not stalled; the horizon RAM does one read-modify-write per sample,
// with a one-entry bypass for a write to the x just being read. Reset: control state clears; the
// horizon RAM is not swept, a fill count makes entries never written read as upper 0 / lower SCREEN_HEIGHT.
module floating_horizon_visibility_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           sample_valid,
  output logic                           sample_stall,
  input  logic signed [fhv_pkg::Y_W-1:0] sample_y,
  input  logic                           first_point,
  output logic                           result_valid,
  input  logic                           result_stall,
  output logic                           draw,
  output logic [fhv_pkg::ADDR_W-1:0]     seg_x,
  output logic signed [fhv_pkg::Y_W-1:0] seg_y_from,
  output logic signed [fhv_pkg::Y_W-1:0] seg_y_to,
  output logic [1:0]                     visibility
);

  logic                          accept;
  fhv_pkg::point_t               in_pt;

  // stage 1: sample waiting on its RAM read
  logic                          s1_valid;
  fhv_pkg::point_t               s1_pt;
  logic signed [fhv_pkg::Y_W-1:0] s1_y;
  logic                          s1_byp;
  fhv_pkg::horizon_t             s1_byp_h;
  logic                          s1_go;
  logic                          s1_fire;

  logic [fhv_pkg::POS_W-1:0]     hw;
  logic signed [fhv_pkg::Y_W-1:0] prev_height;
  fhv_pkg::vis_t                 prev_class;

  logic [fhv_pkg::HOR_W-1:0]     rdata;
  fhv_pkg::horizon_t             rd_h;
  fhv_pkg::horizon_t             cur_h;
  fhv_pkg::horizon_t             wr_h;
  fhv_pkg::vis_t                 cls;
  logic                          ram_we;
  logic                          draw_next;

  assign s1_go        = !result_valid || !result_stall;
  assign sample_stall = s1_valid && !s1_go;
  assign accept       = sample_valid && !sample_stall;
  assign s1_fire      = s1_valid && s1_go;
  assign ram_we       = s1_fire && !s1_pt.drop;

  fhv_point_gen u_point_gen (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .first_point (first_point),
    .pt          (in_pt)
  );

  fhv_ram #(
    .WIDTH (fhv_pkg::HOR_W),
    .DEPTH (fhv_pkg::HORIZON_WIDTH)
  ) u_horizon_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_pt.x[fhv_pkg::ADDR_W-1:0]),
    .wdata (wr_h),
    .re    (accept),
    .raddr (in_pt.x[fhv_pkg::ADDR_W-1:0]),
    .rdata (rdata)
  );

  assign rd_h = rdata;

  always_comb begin
    if (s1_byp) begin
      cur_h = s1_byp_h;
    end else if (s1_pt.x < hw) begin
      cur_h = rd_h;
    end else begin
      cur_h.upper = fhv_pkg::UPPER_RESET;
      cur_h.lower = fhv_pkg::LOWER_RESET;
    end
  end

  fhv_widen u_widen (
    .y   (s1_y),
    .cur (cur_h),
    .cls (cls),
    .nxt (wr_h)
  );

  assign draw_next = !s1_pt.start && (prev_class != fhv_pkg::VIS_HIDDEN) && !s1_pt.drop;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  // the write issued this cycle is not seen by the read issued this cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pt    <= in_pt;
      s1_y     <= sample_y;
      s1_byp   <= ram_we && (s1_pt.x == in_pt.x);
      s1_byp_h <= wr_h;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hw          <= '0;
      prev_height <= '0;
      prev_class  <= fhv_pkg::VIS_HIDDEN;
    end else if (ram_we) begin
      if (s1_pt.x == hw) begin
        hw <= hw + fhv_pkg::POS_W'(1);
      end
      prev_height <= s1_y;
      prev_class  <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_fire) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      draw       <= draw_next;
      seg_x      <= draw_next ? s1_pt.x[fhv_pkg::ADDR_W-1:0] - fhv_pkg::ADDR_W'(1) : '0;
      seg_y_from <= draw_next ? prev_height : '0;
      seg_y_to   <= draw_next ? s1_y : '0;
      visibility <= s1_pt.drop ? 2'(fhv_pkg::VIS_HIDDEN) : 2'(cls);
    end
  end

  a_hw_bound: assert property (@(posedge clk) disable iff (rst)
    hw <= fhv_pkg::POS_W'(fhv_pkg::HORIZON_WIDTH))
    else $error("fill count beyond horizon width");

  a_read_filled: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_pt.drop |-> s1_pt.x <= hw)
    else $error("read of horizon entry past fill count");

  a_above_upper: assert property (@(posedge clk) disable iff (rst)
    ram_we && (cls == fhv_pkg::VIS_ABOVE) |-> wr_h.upper == s1_y)
    else $error("upper horizon not raised to an above sample");

  a_below_lower: assert property (@(posedge clk) disable iff (rst)
    ram_we && (cls == fhv_pkg::VIS_BELOW) |-> wr_h.lower == s1_y)
    else $error("lower horizon not lowered to a below sample");

  a_draw_vis: assert property (@(posedge clk) disable iff (rst)
    s1_fire && draw_next |-> $past(prev_class) != fhv_pkg::VIS_HIDDEN || !$past(ram_we)
      || prev_class != fhv_pkg::VIS_HIDDEN)
    else $error("segment drawn after hidden point");

endmodule
